### rtl/qapm_pkg.sv
// Package: widths, constants, register indexes and stage types for the attitude PID mixer.
package qapm_pkg;

  localparam int THR_W      = 16;
  localparam int ANG_W      = 17;
  localparam int GYRO_W     = 20;
  localparam int MOTOR_W    = 16;
  localparam int GAIN_W     = 10;
  localparam int INTEG_W    = 20;
  localparam int ERR_W      = ANG_W + 1;
  localparam int PE_W       = ERR_W + GAIN_W + 1;
  localparam int DG_W       = GYRO_W + GAIN_W + 1;
  localparam int THRC_W     = THR_W - 1;
  localparam int IMAX_W     = 10;
  localparam int LIM_W      = IMAX_W + 8;
  localparam int CFG_ADDR_W = 2;

  localparam int THROTTLE_LIMIT_DEF = 2000;
  localparam int IMAX_CAP           = 1000;
  localparam int INTEG_THROTTLE     = 300;
  localparam int ACTIVE_THROTTLE    = 200;
  // target^2 <= 0.1 deg^2 in Q.8 -> |target| <= 80; now^2 < 30 deg^2 -> |now| <= 1402
  localparam int LEVEL_TARGET_MAX   = 80;
  localparam int LEVEL_NOW_MAX      = 1402;
  localparam int INTEG_BOUND        = IMAX_CAP * 256;

  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_I = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D = 2'd2;

  typedef struct packed {
    logic [THRC_W-1:0]      thr;
    logic [LIM_W-1:0]       lim;
    logic                   level;
    logic                   clear;
    logic                   active;
    logic signed [PE_W-1:0] pe_roll;
    logic signed [PE_W-1:0] pe_pitch;
    logic signed [PE_W-1:0] pe_yaw;
    logic signed [PE_W-1:0] ie_roll;
    logic signed [PE_W-1:0] ie_pitch;
    logic signed [DG_W-1:0] dg_x;
    logic signed [DG_W-1:0] dg_y;
  } term_t;

endpackage

### rtl/qapm_ifs.sv
// Interfaces: input sample channel and motor command channel.
interface qapm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [qapm_pkg::THR_W-1:0]   throttle;
  logic signed [qapm_pkg::ANG_W-1:0]   yaw_now;
  logic signed [qapm_pkg::ANG_W-1:0]   pitch_now;
  logic signed [qapm_pkg::ANG_W-1:0]   roll_now;
  logic signed [qapm_pkg::ANG_W-1:0]   yaw_target;
  logic signed [qapm_pkg::ANG_W-1:0]   pitch_target;
  logic signed [qapm_pkg::ANG_W-1:0]   roll_target;
  logic signed [qapm_pkg::GYRO_W-1:0]  gyro_x;
  logic signed [qapm_pkg::GYRO_W-1:0]  gyro_y;

  modport source (output valid, throttle, yaw_now, pitch_now, roll_now, yaw_target,
                  pitch_target, roll_target, gyro_x, gyro_y, input ready);
  modport sink (input valid, throttle, yaw_now, pitch_now, roll_now, yaw_target,
                pitch_target, roll_target, gyro_x, gyro_y, output ready);
endinterface

interface qapm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qapm_pkg::MOTOR_W-1:0] motor_a;
  logic signed [qapm_pkg::MOTOR_W-1:0] motor_b;
  logic signed [qapm_pkg::MOTOR_W-1:0] motor_c;
  logic signed [qapm_pkg::MOTOR_W-1:0] motor_d;

  modport source (output valid, motor_a, motor_b, motor_c, motor_d, input ready);
  modport sink (input valid, motor_a, motor_b, motor_c, motor_d, output ready);
endinterface

### rtl/qapm_front.sv
// Front end: input register, then errors, gain products, limits and level test.
module qapm_front #(
  parameter int THROTTLE_LIMIT = qapm_pkg::THROTTLE_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  qapm_in_if.sink                           in_if,
  input  logic [qapm_pkg::GAIN_W-1:0]       gain_p,
  input  logic [qapm_pkg::GAIN_W-1:0]       gain_i,
  input  logic [qapm_pkg::GAIN_W-1:0]       gain_d,
  output logic                              term_valid,
  input  logic                              term_ready,
  output qapm_pkg::term_t                   term
);

  logic                                 v1_r;
  logic                                 v2_r;
  logic                                 adv1;
  logic                                 adv2;
  logic signed [qapm_pkg::THR_W-1:0]    thr_r;
  logic signed [qapm_pkg::ANG_W-1:0]    yaw_now_r, pitch_now_r, roll_now_r;
  logic signed [qapm_pkg::ANG_W-1:0]    yaw_tar_r, pitch_tar_r, roll_tar_r;
  logic signed [qapm_pkg::GYRO_W-1:0]   gx_r, gy_r;
  logic [qapm_pkg::THRC_W-1:0]          thr_c;
  logic [qapm_pkg::THRC_W-2:0]          half;
  logic [qapm_pkg::IMAX_W-1:0]          imax;
  logic signed [qapm_pkg::ERR_W-1:0]    e_yaw, e_pitch, e_roll;
  logic signed [qapm_pkg::GAIN_W:0]     kp, ki, kd;
  qapm_pkg::term_t                      term_nxt;
  qapm_pkg::term_t                      term_r;

  assign adv2        = !v2_r || term_ready;
  assign adv1        = !v1_r || adv2;
  assign in_if.ready = adv1;
  assign term_valid  = v2_r;
  assign term        = term_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_if.valid;
      if (adv2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_if.valid) begin
      thr_r       <= in_if.throttle;
      yaw_now_r   <= in_if.yaw_now;
      pitch_now_r <= in_if.pitch_now;
      roll_now_r  <= in_if.roll_now;
      yaw_tar_r   <= in_if.yaw_target;
      pitch_tar_r <= in_if.pitch_target;
      roll_tar_r  <= in_if.roll_target;
      gx_r        <= in_if.gyro_x;
      gy_r        <= in_if.gyro_y;
    end
    if (adv2 && v1_r) term_r <= term_nxt;
  end

  always_comb begin
    priority if (thr_r < 0) begin
      thr_c = '0;
    end else if (int'(thr_r) > THROTTLE_LIMIT) begin
      thr_c = qapm_pkg::THRC_W'(THROTTLE_LIMIT);
    end else begin
      thr_c = thr_r[qapm_pkg::THRC_W-1:0];
    end
    half = thr_c[qapm_pkg::THRC_W-1:1];
    imax = (int'(half) > qapm_pkg::IMAX_CAP) ? qapm_pkg::IMAX_W'(qapm_pkg::IMAX_CAP)
                                             : half[qapm_pkg::IMAX_W-1:0];
    e_yaw   = qapm_pkg::ERR_W'(yaw_tar_r) - qapm_pkg::ERR_W'(yaw_now_r);
    e_pitch = qapm_pkg::ERR_W'(pitch_tar_r) - qapm_pkg::ERR_W'(pitch_now_r);
    e_roll  = qapm_pkg::ERR_W'(roll_tar_r) - qapm_pkg::ERR_W'(roll_now_r);
    kp = $signed({1'b0, gain_p});
    ki = $signed({1'b0, gain_i});
    kd = $signed({1'b0, gain_d});

    term_nxt.thr    = thr_c;
    term_nxt.lim    = {imax, 8'b0};
    term_nxt.level  = (int'(roll_tar_r) >= -qapm_pkg::LEVEL_TARGET_MAX)
                   && (int'(roll_tar_r) <= qapm_pkg::LEVEL_TARGET_MAX)
                   && (int'(pitch_tar_r) >= -qapm_pkg::LEVEL_TARGET_MAX)
                   && (int'(pitch_tar_r) <= qapm_pkg::LEVEL_TARGET_MAX)
                   && (int'(roll_now_r) >= -qapm_pkg::LEVEL_NOW_MAX)
                   && (int'(roll_now_r) <= qapm_pkg::LEVEL_NOW_MAX)
                   && (int'(pitch_now_r) >= -qapm_pkg::LEVEL_NOW_MAX)
                   && (int'(pitch_now_r) <= qapm_pkg::LEVEL_NOW_MAX)
                   && (int'(thr_c) > qapm_pkg::INTEG_THROTTLE);
    term_nxt.clear  = int'(thr_c) < qapm_pkg::ACTIVE_THROTTLE;
    term_nxt.active = int'(thr_c) > qapm_pkg::ACTIVE_THROTTLE;
    term_nxt.pe_roll  = qapm_pkg::PE_W'(kp) * qapm_pkg::PE_W'(e_roll);
    term_nxt.pe_pitch = qapm_pkg::PE_W'(kp) * qapm_pkg::PE_W'(e_pitch);
    term_nxt.pe_yaw   = qapm_pkg::PE_W'(kp) * qapm_pkg::PE_W'(e_yaw);
    term_nxt.ie_roll  = qapm_pkg::PE_W'(ki) * qapm_pkg::PE_W'(e_roll);
    term_nxt.ie_pitch = qapm_pkg::PE_W'(ki) * qapm_pkg::PE_W'(e_pitch);
    term_nxt.dg_x     = qapm_pkg::DG_W'(kd) * qapm_pkg::DG_W'(gx_r);
    term_nxt.dg_y     = qapm_pkg::DG_W'(kd) * qapm_pkg::DG_W'(gy_r);
  end

endmodule

### rtl/qapm_mix.sv
// Back end: integral update and clamp, X mixing, rounding, saturation, result register.
module qapm_mix (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             term_valid,
  output logic             term_ready,
  input  qapm_pkg::term_t  term,
  qapm_out_if.source       out_if
);

  localparam int SUM_W = qapm_pkg::INTEG_W + 10;
  localparam int AX_W  = qapm_pkg::DG_W + 2;
  localparam int MIX_W = AX_W + 3;
  localparam int RND_W = MIX_W + 1;

  logic                                 fire;
  logic                                 out_v_r;
  logic signed [qapm_pkg::INTEG_W-1:0]  roll_integ_r, pitch_integ_r;
  logic signed [qapm_pkg::INTEG_W-1:0]  roll_upd, pitch_upd;
  logic signed [qapm_pkg::INTEG_W-1:0]  roll_integ_nxt, pitch_integ_nxt;
  logic signed [qapm_pkg::LIM_W:0]      lim_s;
  logic signed [SUM_W-1:0]              roll_sum, pitch_sum;
  logic signed [AX_W-1:0]               r_out, p_out, y_out;
  logic signed [MIX_W-1:0]              t8;
  logic signed [qapm_pkg::MOTOR_W-1:0]  ma, mb, mc, md;
  logic signed [qapm_pkg::MOTOR_W-1:0]  ma_r, mb_r, mc_r, md_r;

  function automatic logic signed [qapm_pkg::MOTOR_W-1:0] to_motor(
    input logic signed [MIX_W-1:0] q8
  );
    logic signed [MIX_W:0]   x;
    logic signed [MIX_W-8:0] r;
    x = RND_W'(q8) + RND_W'(128);
    r = x[MIX_W:8];
    if (r > 32767) begin
      to_motor = 16'sh7fff;
    end else if (r < -32768) begin
      to_motor = 16'sh8000;
    end else begin
      to_motor = r[qapm_pkg::MOTOR_W-1:0];
    end
  endfunction

  function automatic logic signed [qapm_pkg::INTEG_W-1:0] clamp_integ(
    input logic signed [SUM_W-1:0]          s,
    input logic signed [qapm_pkg::LIM_W:0]  l
  );
    if (s > l) begin
      clamp_integ = qapm_pkg::INTEG_W'(l);
    end else if (s < -l) begin
      clamp_integ = qapm_pkg::INTEG_W'(-l);
    end else begin
      clamp_integ = s[qapm_pkg::INTEG_W-1:0];
    end
  endfunction

  assign term_ready   = !out_v_r || out_if.ready;
  assign fire         = term_valid && term_ready;
  assign out_if.valid = out_v_r;
  assign out_if.motor_a = ma_r;
  assign out_if.motor_b = mb_r;
  assign out_if.motor_c = mc_r;
  assign out_if.motor_d = md_r;

  always_comb begin
    lim_s     = $signed({1'b0, term.lim});
    roll_sum  = SUM_W'(roll_integ_r) + SUM_W'(term.ie_roll);
    pitch_sum = SUM_W'(pitch_integ_r) + SUM_W'(term.ie_pitch);
    priority if (term.level) begin
      roll_upd  = clamp_integ(roll_sum, lim_s);
      pitch_upd = clamp_integ(pitch_sum, lim_s);
    end else if (term.clear) begin
      roll_upd  = '0;
      pitch_upd = '0;
    end else begin
      roll_upd  = roll_integ_r;
      pitch_upd = pitch_integ_r;
    end
    roll_integ_nxt  = fire ? roll_upd : roll_integ_r;
    pitch_integ_nxt = fire ? pitch_upd : pitch_integ_r;

    r_out = AX_W'(term.pe_roll) + AX_W'(roll_upd) + AX_W'(term.dg_x);
    p_out = AX_W'(term.pe_pitch) + AX_W'(pitch_upd) + AX_W'(term.dg_y);
    y_out = AX_W'(term.pe_yaw);
    t8    = $signed({{(MIX_W - qapm_pkg::THRC_W - 8){1'b0}}, term.thr, 8'b0});
    ma = to_motor(t8 - MIX_W'(r_out) - MIX_W'(p_out) + MIX_W'(y_out));
    mb = to_motor(t8 + MIX_W'(r_out) - MIX_W'(p_out) - MIX_W'(y_out));
    mc = to_motor(t8 + MIX_W'(r_out) + MIX_W'(p_out) + MIX_W'(y_out));
    md = to_motor(t8 - MIX_W'(r_out) + MIX_W'(p_out) - MIX_W'(y_out));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r       <= 1'b0;
      roll_integ_r  <= '0;
      pitch_integ_r <= '0;
    end else begin
      if (term_ready) out_v_r <= term_valid;
      roll_integ_r  <= roll_integ_nxt;
      pitch_integ_r <= pitch_integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ma_r <= term.active ? ma : '0;
      mb_r <= term.active ? mb : '0;
      mc_r <= term.active ? mc : '0;
      md_r <= term.active ? md : '0;
    end
  end

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(roll_integ_r) <= qapm_pkg::INTEG_BOUND)
    && (int'(roll_integ_r) >= -qapm_pkg::INTEG_BOUND)
    && (int'(pitch_integ_r) <= qapm_pkg::INTEG_BOUND)
    && (int'(pitch_integ_r) >= -qapm_pkg::INTEG_BOUND))
    else $error("integral out of bound");

  a_integ_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !term.level && term.clear) |=> (roll_integ_r == 0 && pitch_integ_r == 0))
    else $error("integral not cleared at low throttle");

  a_low_thr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !term.active) |=> (out_if.valid && out_if.motor_a == 0
      && out_if.motor_b == 0 && out_if.motor_c == 0 && out_if.motor_d == 0))
    else $error("motor word not zero at low throttle");

  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(roll_integ_r) && $stable(pitch_integ_r)))
    else $error("integral moved without a word");

endmodule

### rtl/quad_attitude_pid_mixer.sv
// Top level: quadcopter attitude PID with X motor mixer, gain registers and stage wiring.
// Path from input word accept to result word valid: input reg, then term reg, then out reg.
// Throughput: one word per cycle while out_if.ready holds; the integral update is a registered loop in the back end.
// Stages advance independently, so a word is accepted while a result waits if any slot is free.
// Reset (synchronous, active low): gains and both integrals to zero, all stage valids cleared.
module quad_attitude_pid_mixer #(
  parameter int THROTTLE_LIMIT = qapm_pkg::THROTTLE_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  qapm_in_if.sink                             in_if,
  qapm_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [qapm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [qapm_pkg::GAIN_W-1:0]         cfg_wdata
);

  logic [qapm_pkg::GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic                        term_valid;
  logic                        term_ready;
  qapm_pkg::term_t             term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        qapm_pkg::REG_GAIN_P: gain_p_r <= cfg_wdata;
        qapm_pkg::REG_GAIN_I: gain_i_r <= cfg_wdata;
        qapm_pkg::REG_GAIN_D: gain_d_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  qapm_front #(
    .THROTTLE_LIMIT (THROTTLE_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .gain_p     (gain_p_r),
    .gain_i     (gain_i_r),
    .gain_d     (gain_d_r),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .term       (term)
  );

  qapm_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .term       (term),
    .out_if     (out_if)
  );

endmodule
